// File: rtl/ffa_pkg.sv
// ffa_pkg: request and response word types, arena constants and mode codes
// for the first fit free list allocator; no dependencies
package ffa_pkg;
   localparam int HEAP_SLOTS = 1024;
   localparam int UNIT_BYTES = 16;

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_CALLOC = 2'd1;
   localparam logic [1:0] MODE_FREE   = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] byte_count;
      logic [15:0] element_count;
      logic [15:0] element_size;
      logic [9:0]  block_unit;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [9:0]  data_unit;
      logic [9:0]  granted_units;
      logic        clear_needed;
      logic [13:0] clear_bytes;
   } rsp_type;
endpackage

// File: rtl/first_fit_free_list_allocator.sv
// first_fit_free_list_allocator: address ordered free list over a fixed arena
// kept in two synchronous memories (sizes, links); uses ffa_pkg
//
//  channel | dir | handshake          | word
//  req     | in  | req_valid/req_stall | ffa_pkg::req_type
//  rsp     | out | rsp_valid/rsp_stall | ffa_pkg::rsp_type
//
// one item at a time; after acceptance an allocate runs S_MUL for a calloc,
// S_NEED, S_ARD, S_ACHK per free list node visited, S_ASPL when a block is
// split, and S_RSP; an oversized request skips from S_NEED to S_RSP. a free
// runs S_FRD, S_FCHK per node visited, S_FBP, S_FUP, S_FLO and S_RSP, the
// sentinel just S_FRD, S_RSP. after reset a clearing pass writes every size
// and link entry, no request taken meanwhile. the response register holds a
// word while rsp_stall is high; the next request is taken once it is empty.
module first_fit_free_list_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffa_pkg::rsp_type rsp_data
);
   import ffa_pkg::*;

   localparam int AW = $clog2(HEAP_SLOTS);
   localparam int UB = $clog2(UNIT_BYTES);
   localparam int CW = AW + 2;   // walk step counter, holds HEAP_SLOTS+1
   localparam logic [AW-1:0] LAST = AW'(HEAP_SLOTS - 1);

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_MUL = 4'd2,
      S_NEED = 4'd3, S_ARD = 4'd4, S_ACHK = 4'd5, S_FRD = 4'd6,
      S_FCHK = 4'd7, S_FBP = 4'd8, S_ASPL = 4'd9, S_FUP = 4'd10,
      S_FLO = 4'd11, S_RSP = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [AW-1:0] rover_ff, rover_in, prev_ff, prev_in, cur_ff, cur_in;
   logic [AW-1:0] bp_ff, bp_in, n_ff, n_in, clr_ff, clr_in;
   logic [AW-1:0] bsz_ff, bsz_in, bnx_ff, bnx_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [AW:0] need_ff, need_in;
   logic [31:0] prod_ff, prod_in;
   logic [1:0] mode_ff, mode_in;
   logic [15:0] ec_ff, es_ff;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;

   // memories
   logic [AW-1:0] size_mem [HEAP_SLOTS];
   logic [AW-1:0] link_mem [HEAP_SLOTS];
   logic [AW-1:0] rd_addr, size_q, link_q;
   logic          sw_en, lw_en;
   logic [AW-1:0] sw_addr, sw_data, lw_addr, lw_data;

   always_ff @(posedge clock) begin
      size_q <= size_mem[rd_addr];
      link_q <= link_mem[rd_addr];
      if (sw_en) size_mem[sw_addr] <= sw_data;
      if (lw_en) link_mem[lw_addr] <= lw_data;
   end

   logic accept;
   assign req_stall = !(state_ff == S_IDLE && !rv_ff);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   logic [31:0] ceil_units;
   logic [AW:0] size_need_cmp;
   logic [AW-1:0] rem;
   logic free_hit;
   logic [AW:0] bp_sum, p_sum;

   always_comb begin
      state_in = state_ff; rover_in = rover_ff; prev_in = prev_ff; cur_in = cur_ff;
      bp_in = bp_ff; n_in = n_ff; clr_in = clr_ff; steps_in = steps_ff;
      need_in = need_ff; prod_in = prod_ff; mode_in = mode_ff;
      bsz_in = bsz_ff; bnx_in = bnx_ff;
      rsp_in = rsp_ff; rv_in = rv_ff;
      rd_addr = cur_ff;
      sw_en = 1'b0; sw_addr = '0; sw_data = '0;
      lw_en = 1'b0; lw_addr = '0; lw_data = '0;
      ceil_units = '0;
      size_need_cmp = {1'b0, size_q};
      rem = size_q - need_ff[AW-1:0];
      free_hit = 1'b0;
      bp_sum = '0; p_sum = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (state_ff)
         S_CLR: begin
            // clearing pass, which writes the initial list as it goes
            lw_en = 1'b1; lw_addr = clr_ff;
            lw_data = (clr_ff == '0) ? AW'(1) : '0;
            sw_en = 1'b1; sw_addr = clr_ff;
            sw_data = (clr_ff == AW'(1)) ? LAST : '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               mode_in = req_data.mode;
               prod_in = {16'd0, req_data.byte_count};
               bp_in = req_data.block_unit[AW-1:0] - 1'b1;
               case (req_data.mode)
                  MODE_ALLOC:  state_in = S_NEED;
                  MODE_CALLOC: state_in = S_MUL;
                  MODE_FREE: begin
                     state_in = S_FRD; cur_in = rover_ff; steps_in = '0;
                  end
                  default: begin
                     rsp_in = '0; state_in = S_RSP;
                  end
               endcase
            end
         end
         S_MUL: begin
            prod_in = ec_ff * es_ff;
            state_in = S_NEED;
         end
         S_NEED: begin
            // units = ceil(bytes/unit)+1, oversize fails
            ceil_units = (prod_ff + 32'(UNIT_BYTES - 1)) >> UB;
            if (ceil_units >= 32'(HEAP_SLOTS - 1)) begin
               rsp_in = '0; rsp_in.status = 1'b1; state_in = S_RSP;
            end else begin
               need_in = (AW+1)'(ceil_units + 32'd1);
               prev_in = rover_ff; rd_addr = rover_ff; steps_in = '0;
               state_in = S_ARD;
            end
         end
         S_ARD: begin
            // link of prev arrives; read cur
            cur_in = link_q; rd_addr = link_q;
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (size_need_cmp >= need_ff) begin
               rover_in = prev_ff;
               rsp_in = '0;
               rsp_in.granted_units = 10'(need_ff);
               rsp_in.clear_needed = (mode_ff == MODE_CALLOC);
               rsp_in.clear_bytes = (mode_ff == MODE_CALLOC) ? prod_ff[13:0] : 14'd0;
               if (size_need_cmp == need_ff) begin
                  lw_en = 1'b1; lw_addr = prev_ff; lw_data = link_q;
                  rsp_in.data_unit = 10'(cur_ff + 1'b1);
                  state_in = S_RSP;
               end else begin
                  // shrink the block now, header of the tail next cycle
                  sw_en = 1'b1; sw_addr = cur_ff; sw_data = rem;
                  bp_in = cur_ff + rem;
                  rsp_in.data_unit = 10'(cur_ff + rem + 1'b1);
                  state_in = S_ASPL;
               end
            end else if (cur_ff == rover_ff || steps_ff == CW'(HEAP_SLOTS)) begin
               rsp_in = '0; rsp_in.status = 1'b1; state_in = S_RSP;
            end else begin
               prev_in = cur_ff; cur_in = link_q; rd_addr = link_q;
               steps_in = steps_ff + 1'b1;
            end
         end
         S_ASPL: begin
            // size of the split off tail
            sw_en = 1'b1; sw_addr = bp_ff; sw_data = need_ff[AW-1:0];
            state_in = S_RSP;
         end
         S_FRD: begin
            if (bp_ff == '0) begin
               rsp_in = '0; state_in = S_RSP;
            end else begin
               rd_addr = cur_ff; state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            // cur is p, link_q is n
            free_hit = (bp_ff > cur_ff && bp_ff < link_q) ||
               (cur_ff >= link_q && (bp_ff > cur_ff || bp_ff < link_q));
            if (free_hit) begin
               n_in = link_q; bsz_in = size_q; rd_addr = bp_ff; state_in = S_FBP;
            end else if (steps_ff == CW'(HEAP_SLOTS)) begin
               rsp_in = '0; state_in = S_RSP;
            end else begin
               cur_in = link_q; rd_addr = link_q; steps_in = steps_ff + 1'b1;
            end
         end
         S_FBP: begin
            // bp size in size_q; hold it, read n
            bnx_in = size_q; rd_addr = n_ff; state_in = S_FUP;
         end
         S_FUP: begin
            // size_q/link_q are of n; bnx holds bp size
            bp_sum = {1'b0, bp_ff} + {1'b0, bnx_ff};
            if (bp_sum == {1'b0, n_ff}) begin
               bnx_in = bnx_ff + size_q;
               sw_en = 1'b1; sw_addr = bp_ff; sw_data = bnx_ff + size_q;
               lw_en = 1'b1; lw_addr = bp_ff; lw_data = link_q;
               n_in = link_q;
            end else begin
               lw_en = 1'b1; lw_addr = bp_ff; lw_data = n_ff;
            end
            state_in = S_FLO;
         end
         S_FLO: begin
            // cur is p, bsz its size, n is bp's new link
            p_sum = {1'b0, cur_ff} + {1'b0, bsz_ff};
            if (p_sum == {1'b0, bp_ff}) begin
               sw_en = 1'b1; sw_addr = cur_ff; sw_data = bsz_ff + bnx_ff;
               lw_en = 1'b1; lw_addr = cur_ff; lw_data = n_ff;
            end else begin
               lw_en = 1'b1; lw_addr = cur_ff; lw_data = bp_ff;
            end
            rover_in = cur_ff; rsp_in = '0; state_in = S_RSP;
         end
         S_RSP: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; rover_ff <= '0; clr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rover_ff <= rover_in; clr_ff <= clr_in; rv_ff <= rv_in;
      end
      prev_ff <= prev_in; cur_ff <= cur_in; bp_ff <= bp_in; n_ff <= n_in;
      steps_ff <= steps_in; need_ff <= need_in; prod_ff <= prod_in;
      mode_ff <= mode_in; bsz_ff <= bsz_in; bnx_ff <= bnx_in; rsp_ff <= rsp_in;
      if (accept) begin
         ec_ff <= req_data.element_count; es_ff <= req_data.element_size;
      end
   end

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> req_stall) else $error("request taken while response pending");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_ff.status) |-> (rsp_ff.data_unit == '0 && rsp_ff.granted_units == '0))
      else $error("failed grant carries data");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rsp_ff)))
      else $error("stalled response changed");
endmodule

// File: verif/tb.sv
// tb: self-checking bench for first_fit_free_list_allocator; drives request
// words, predicts each response with a behavioral copy of the free list
// depends on ffa_pkg and rtl/first_fit_free_list_allocator.sv
`timescale 1ns / 100ps

module tb;
   import ffa_pkg::*;

   localparam int SLOTS    = 1024;
   localparam int UBYTES   = 16;
   localparam int N_RANDOM = 600;
   localparam int LIMIT    = 2000000;
   localparam logic [1:0] MODE_NONE = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   first_fit_free_list_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor state: arena sizes, links, rover
   int unsigned arena_size [SLOTS];
   int unsigned arena_next [SLOTS];
   int unsigned rover_slot;

   rsp_type pending_rsp[$];
   int      mismatch_count = 0;
   int      rsp_count = 0;
   int      grant_count = 0;
   int      deny_count = 0;
   int      free_count = 0;
   longint  cycle_count = 0;
   bit      stim_done = 0;
   bit      hold_off = 0;
   bit      hold_sent = 0;

   // live grants for well-formed frees
   logic [9:0] live_units[$];

   // directed stimulus table; exp_valid marks rows with a typed-in answer
   typedef struct {
      req_type req;
      bit      exp_valid;
      rsp_type exp;
   } stim_row;
   stim_row dir_table[$];

   function automatic void arena_reset();
      for (int i = 0; i < SLOTS; i++) begin
         arena_size[i] = 0;
         arena_next[i] = 0;
      end
      arena_size[1] = SLOTS - 1;
      arena_next[0] = 1;
      rover_slot = 0;
   endfunction

   // first fit search from rover; splits off tail or unlinks exact fit
   function automatic bit arena_take(longint unsigned nbytes,
                                     output int unsigned hdr,
                                     output int unsigned units);
      longint unsigned need;
      int unsigned prv, cur;
      need = (nbytes + UBYTES - 1) / UBYTES + 1;
      hdr = 0;
      units = 0;
      if (need > SLOTS - 1) return 0;
      prv = rover_slot;
      cur = arena_next[prv];
      for (int s = 0; s <= SLOTS; s++) begin
         if (arena_size[cur] >= need) begin
            hdr = cur;
            if (arena_size[cur] == need) begin
               arena_next[prv] = arena_next[cur];
            end else begin
               arena_size[cur] -= need;
               hdr = (cur + arena_size[cur]) % SLOTS;
               arena_size[hdr] = need;
            end
            rover_slot = prv;
            units = need;
            return 1;
         end
         if (cur == rover_slot) return 0;
         prv = cur;
         cur = arena_next[cur];
      end
      return 0;
   endfunction

   // address ordered insert with joins on both sides
   function automatic void arena_give(int unsigned bp);
      int unsigned p, n;
      bit found;
      p = rover_slot;
      found = 0;
      if (bp == 0) return;
      for (int s = 0; s <= SLOTS; s++) begin
         n = arena_next[p];
         if (bp > p && bp < n) begin found = 1; break; end
         if (p >= n && (bp > p || bp < n)) begin found = 1; break; end
         p = n;
      end
      if (!found) return;
      n = arena_next[p];
      if (bp + arena_size[bp] == n) begin
         arena_size[bp] = (arena_size[bp] + arena_size[n]) % SLOTS;
         arena_next[bp] = arena_next[n];
      end else begin
         arena_next[bp] = n;
      end
      if (p + arena_size[p] == bp) begin
         arena_size[p] = (arena_size[p] + arena_size[bp]) % SLOTS;
         arena_next[p] = arena_next[bp];
      end else begin
         arena_next[p] = bp;
      end
      rover_slot = p;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      longint unsigned nb;
      int unsigned hdr, units;
      o = '0;
      if (r.mode == MODE_ALLOC || r.mode == MODE_CALLOC) begin
         if (r.mode == MODE_ALLOC) nb = r.byte_count;
         else nb = longint'(r.element_count) * longint'(r.element_size);
         if (arena_take(nb, hdr, units)) begin
            o.data_unit     = 10'((hdr + 1) % SLOTS);
            o.granted_units = 10'(units);
            o.clear_needed  = (r.mode == MODE_CALLOC);
            o.clear_bytes   = (r.mode == MODE_CALLOC) ? 14'(nb) : 14'd0;
            grant_count++;
            live_units.push_back(o.data_unit);
         end else begin
            o.status = 1'b1;
            deny_count++;
         end
      end else if (r.mode == MODE_FREE) begin
         arena_give((int'(r.block_unit) + SLOTS - 1) % SLOTS);
         free_count++;
      end
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] m, int bc, int ec, int es, int bu);
      req_type r;
      r.mode = m;
      r.byte_count = 16'(bc);
      r.element_count = 16'(ec);
      r.element_size = 16'(es);
      r.block_unit = 10'(bu);
      return r;
   endfunction

   function automatic rsp_type make_rsp(bit st, int du, int gu, bit cn, int cb);
      rsp_type o;
      o.status = st;
      o.data_unit = 10'(du);
      o.granted_units = 10'(gu);
      o.clear_needed = cn;
      o.clear_bytes = 14'(cb);
      return o;
   endfunction

   function automatic void add_row(req_type r, bit ev, rsp_type e);
      stim_row row;
      row.req = r;
      row.exp_valid = ev;
      row.exp = e;
      dir_table.push_back(row);
   endfunction

   function automatic req_type random_req();
      req_type r;
      int pick;
      r = '0;
      r.byte_count = 16'($urandom);
      r.element_count = 16'($urandom);
      r.element_size = 16'($urandom);
      r.block_unit = 10'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.mode = MODE_ALLOC;
         if ($urandom_range(0, 9) != 0) r.byte_count = 16'($urandom_range(0, 400));
      end else if (pick < 45) begin
         r.mode = MODE_CALLOC;
         if ($urandom_range(0, 9) != 0) begin
            r.element_count = 16'($urandom_range(0, 20));
            r.element_size = 16'($urandom_range(0, 40));
         end
      end else if (pick < 85 && live_units.size() > 0) begin
         // well-formed free of a live grant
         int idx;
         idx = $urandom_range(0, live_units.size() - 1);
         r.mode = MODE_FREE;
         r.block_unit = live_units[idx];
         live_units.delete(idx);
      end else if (pick < 92) begin
         r.mode = MODE_NONE;
      end else begin
         // free of the sentinel only: other stray frees may read unwritten sizes
         r.mode = MODE_FREE;
         r.block_unit = 10'd1;
      end
      return r;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // receiver stall pattern, with long hold-off on request
   initial begin
      int hold;
      rsp_stall <= 1'b1;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            for (hold = 0; hold < 3000; hold++) @(posedge clock);
            hold_off = 0;
         end
         if (cycle_count % 2000 < 600) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // response checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status
                || rsp_data.data_unit !== want.data_unit
                || rsp_data.granted_units !== want.granted_units
                || rsp_data.clear_needed !== want.clear_needed
                || rsp_data.clear_bytes !== want.clear_bytes) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   // sender: bursts and gaps
   task automatic send_word(req_type r, bit ev, rsp_type e);
      rsp_type p;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_rsp(r);
      if (ev && p !== e) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("table row disagrees: %p vs %p", e, p);
      end
      pending_rsp.push_back(ev ? e : p);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int burst, waited;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      arena_reset();

      // directed rows: extremes and each special case
      add_row(make_req(MODE_NONE, 65535, 65535, 65535, 1023), 1, make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(MODE_ALLOC, 65535, 0, 0, 0), 1, make_rsp(1, 0, 0, 0, 0));
      add_row(make_req(MODE_CALLOC, 0, 65535, 65535, 0), 1, make_rsp(1, 0, 0, 0, 0));
      add_row(make_req(MODE_CALLOC, 0, 256, 256, 0), 1, make_rsp(1, 0, 0, 0, 0));
      add_row(make_req(MODE_ALLOC, 0, 0, 0, 0), 1, make_rsp(0, 0, 1, 0, 0));
      add_row(make_req(MODE_FREE, 0, 0, 0, 1), 1, make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(MODE_ALLOC, 16, 0, 0, 0), 1, make_rsp(0, 1022, 2, 0, 0));
      add_row(make_req(MODE_CALLOC, 0, 3, 5, 0), 1, make_rsp(0, 1020, 2, 1, 15));
      add_row(make_req(MODE_FREE, 0, 0, 0, 0), 0, '0);
      add_row(make_req(MODE_FREE, 0, 0, 0, 1022), 0, '0);
      add_row(make_req(MODE_ALLOC, 16352, 0, 0, 0), 0, '0);
      add_row(make_req(MODE_FREE, 0, 0, 0, 1020), 0, '0);
      add_row(make_req(MODE_ALLOC, 16336, 0, 0, 0), 0, '0);
      add_row(make_req(MODE_ALLOC, 17, 0, 0, 0), 0, '0);
      add_row(make_req(MODE_FREE, 0, 0, 0, 2), 0, '0);
      add_row(make_req(MODE_CALLOC, 0, 1, 16336, 0), 0, '0);
      add_row(make_req(MODE_CALLOC, 0, 16336, 1, 0), 0, '0);
      add_row(make_req(MODE_ALLOC, 1, 0, 0, 0), 0, '0);
      add_row(make_req(MODE_FREE, 0, 0, 0, 3), 0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) send_word(dir_table[i].req, dir_table[i].exp_valid,
                                       dir_table[i].exp);
      // reset-based rows only hold in order; drop live list from directed part
      live_units.delete();

      for (int k = 0; k < N_RANDOM; k++) begin
         if (k >= N_RANDOM / 2 && !hold_sent) begin
            hold_off = 1;
            hold_sent = 1;
         end
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && k < N_RANDOM; b++, k++) send_word(random_req(), 0, '0);
         k--;
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
      end
      req_valid <= 1'b0;
      stim_done = 1;

      waited = 0;
      while (pending_rsp.size() != 0 && waited < 500000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);

      $display("covered %0d responses: %0d grants, %0d denials, %0d frees",
               rsp_count, grant_count, deny_count, free_count);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d words outstanding", mismatch_count,
                  pending_rsp.size());
         $display("FAIL");
      end
      $finish;
   end
endmodule
